### rtl/poisson_residual_stencil_top_macros.svh
// Assertion shorthands shared by the stencil modules.
// Both sample on clk and are muted while rst is high.
`ifndef POISSON_RESIDUAL_STENCIL_TOP_MACROS_SVH
`define POISSON_RESIDUAL_STENCIL_TOP_MACROS_SVH

// Same-cycle implication.
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/prs_pkg.sv
package prs_pkg;

  localparam int MAX_PANELS = 1024;
  localparam int ROW_DEPTH  = MAX_PANELS + 1;
  localparam int CNT_W      = $clog2(ROW_DEPTH);
  localparam int PANEL_MIN  = 2;

  localparam int VALUE_W    = 32;
  localparam int COEF_W     = 32;
  localparam int HALF_W     = COEF_W / 2;
  localparam int FRAC_SHIFT = 8;

  // left + right - 2*mid fits in two extra bits; DIFF_W keeps three
  localparam int DIFF_W = VALUE_W + 3;
  localparam int PROD_W = DIFF_W + HALF_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int C_W    = SUM_W + 2;
  localparam int Q_W    = C_W - FRAC_SHIFT;
  localparam int R_W    = SUM_W + FRAC_SHIFT + 1;

  localparam logic signed [C_W-1:0] ROUND_HALF = C_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [R_W-1:0] SAT_HI =
    {{(R_W - VALUE_W + 1){1'b0}}, {(VALUE_W - 1){1'b1}}};
  localparam logic signed [R_W-1:0] SAT_LO = ~SAT_HI;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 2'd3;

  localparam logic [CNT_W-1:0]  PANELS_RESET = CNT_W'(16);
  localparam logic [COEF_W-1:0] COEF_RESET   = COEF_W'(131072);

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] f;
    logic signed [VALUE_W-1:0] recent;
    logic signed [VALUE_W-1:0] older;
  } prs_word_t;

  typedef struct packed {
    logic             has_int;
    logic             interior;
    logic             has_edge;
    logic             edge_done;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] row;
  } prs_meta_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          col;
    logic [CNT_W-1:0]          row;
    logic                      done;
  } prs_result_t;

  function automatic logic [CNT_W-1:0] clamp_panels(input logic [CNT_W-1:0] p);
    logic [CNT_W-1:0] q;
    q = p;
    if (p < CNT_W'(PANEL_MIN)) begin
      q = CNT_W'(PANEL_MIN);
    end else if (p > CNT_W'(MAX_PANELS)) begin
      q = CNT_W'(MAX_PANELS);
    end
    return q;
  endfunction

endpackage

### rtl/prs_row_store.sv
`include "poisson_residual_stencil_top_macros.svh"

module prs_row_store (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [prs_pkg::CNT_W-1:0]          col,
  input  logic [prs_pkg::CNT_W-1:0]          col_ahead,
  input  prs_pkg::prs_meta_t                 meta,
  input  logic signed [prs_pkg::VALUE_W-1:0] u_in,
  input  logic signed [prs_pkg::VALUE_W-1:0] f_in,
  output logic                               st_valid,
  output prs_pkg::prs_meta_t                 st_meta,
  output logic signed [prs_pkg::DIFF_W-1:0]  st_dx,
  output logic signed [prs_pkg::DIFF_W-1:0]  st_dy,
  output logic signed [prs_pkg::VALUE_W-1:0] st_f
);
  import prs_pkg::*;

  prs_word_t mem [0:ROW_DEPTH-1];

  // rd_word runs one column ahead of cur_word
  prs_word_t                 rd_word;
  prs_word_t                 cur_word;
  logic signed [VALUE_W-1:0] left_u;

  logic                      s1_valid;
  logic [CNT_W-1:0]          s1_col;
  prs_meta_t                 s1_meta;
  logic signed [VALUE_W-1:0] s1_u;
  logic signed [VALUE_W-1:0] s1_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      st_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      st_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word  <= mem[col_ahead];
      cur_word <= rd_word;
      left_u   <= cur_word.recent;
      s1_col   <= col;
      s1_meta  <= meta;
      s1_u     <= u_in;
      s1_f     <= f_in;
    end
  end

  // shift the column down one row: recent becomes older
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_col] <= '{f: s1_f, recent: s1_u, older: cur_word.recent};
    end
  end

  always_ff @(posedge clk) begin
    st_meta <= s1_meta;
    st_f    <= cur_word.f;
    st_dx   <= DIFF_W'(left_u) + DIFF_W'(rd_word.recent) - (DIFF_W'(cur_word.recent) <<< 1);
    st_dy   <= DIFF_W'(cur_word.older) + DIFF_W'(s1_u) - (DIFF_W'(cur_word.recent) <<< 1);
  end

  `PRS_ASSERT_NOW(a_no_rw_collide, s1_valid && accept, s1_col != col_ahead, "row store read hits pending write")
  `PRS_ASSERT_NEXT(a_write_once, s1_valid && !accept, !s1_valid, "row store wrote a column twice")

endmodule

### rtl/prs_arith.sv
module prs_arith (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               st_valid,
  input  prs_pkg::prs_meta_t                 st_meta,
  input  logic signed [prs_pkg::DIFF_W-1:0]  st_dx,
  input  logic signed [prs_pkg::DIFF_W-1:0]  st_dy,
  input  logic signed [prs_pkg::VALUE_W-1:0] st_f,
  input  logic [prs_pkg::COEF_W-1:0]         coef_x,
  input  logic [prs_pkg::COEF_W-1:0]         coef_y,
  output logic                               res_valid,
  output prs_pkg::prs_meta_t                 res_meta,
  output logic signed [prs_pkg::VALUE_W-1:0] res_value
);
  import prs_pkg::*;

  logic signed [PROD_W-1:0] cxh, cxl, cyh, cyl;

  logic                      v3;
  prs_meta_t                 meta3;
  logic signed [VALUE_W-1:0] f3;
  logic signed [PROD_W-1:0]  p_ax, p_ay, p_bx, p_by;

  logic signed [C_W-1:0]     cval;
  logic signed [SUM_W-1:0]   a4;
  logic signed [Q_W-1:0]     q4;
  logic signed [R_W-1:0]     r_wide;

  // coefficient halves as non-negative signed operands
  assign cxh = PROD_W'($signed({1'b0, coef_x[COEF_W-1:HALF_W]}));
  assign cxl = PROD_W'($signed({1'b0, coef_x[HALF_W-1:0]}));
  assign cyh = PROD_W'($signed({1'b0, coef_y[COEF_W-1:HALF_W]}));
  assign cyl = PROD_W'($signed({1'b0, coef_y[HALF_W-1:0]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v3        <= st_valid;
      res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    meta3 <= st_meta;
    f3    <= st_f;
    p_ax  <= cxh * PROD_W'(st_dx);
    p_ay  <= cyh * PROD_W'(st_dy);
    p_bx  <= cxl * PROD_W'(st_dx);
    p_by  <= cyl * PROD_W'(st_dy);
  end

  // low halves fold into f with round-half-up; high halves stay exact
  assign cval = (C_W'(f3) <<< FRAC_SHIFT) - C_W'(p_bx) - C_W'(p_by) + ROUND_HALF;

  always_ff @(posedge clk) begin
    res_meta <= meta3;
    a4       <= SUM_W'(p_ax) + SUM_W'(p_ay);
    q4       <= Q_W'(cval >>> FRAC_SHIFT);
  end

  assign r_wide = R_W'(q4) - (R_W'(a4) <<< FRAC_SHIFT);

  always_comb begin
    if (!res_meta.interior) begin
      res_value = '0;
    end else if (r_wide > SAT_HI) begin
      res_value = VALUE_W'(SAT_HI);
    end else if (r_wide < SAT_LO) begin
      res_value = VALUE_W'(SAT_LO);
    end else begin
      res_value = VALUE_W'(r_wide);
    end
  end

endmodule

### rtl/prs_out_fifo.sv
`include "poisson_residual_stencil_top_macros.svh"

module prs_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_first,
  input  logic                  wr_second,
  input  prs_pkg::prs_result_t  ent_first,
  input  prs_pkg::prs_result_t  ent_second,
  input  logic                  pop,
  output logic                  head_valid,
  output prs_pkg::prs_result_t  head
);
  import prs_pkg::*;

  prs_result_t slots [0:FIFO_DEPTH-1];

  logic [FIFO_AW-1:0] rd_ptr, wr_ptr, wr_ptr_next;
  logic [FIFO_CW-1:0] count, count_next;
  logic [FIFO_CW-1:0] n_push;

  assign n_push      = FIFO_CW'(wr_first) + FIFO_CW'(wr_second);
  assign wr_ptr_next = wr_ptr + FIFO_AW'(n_push);
  assign count_next  = count + n_push - FIFO_CW'(pop);
  assign head_valid  = (count != '0);
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      slots[wr_ptr] <= ent_first;
    end
    if (wr_second) begin
      slots[wr_ptr + FIFO_AW'(1)] <= ent_second;
    end
  end

  `PRS_ASSERT_NOW(a_fifo_bound, 1'b1, count <= FIFO_CW'(FIFO_DEPTH), "result queue overflow")

endmodule

### rtl/poisson_residual_stencil_top.sv
// Channel  Handshake            Word
// -------  -------------------  ------------------------------------------
// in       in_valid / in_stall  u_value, f_value (one grid point, raster)
// out      out_valid/out_stall  residual_value, out_col, out_row, grid_done
// cfg      cfg_write            cfg_index, cfg_data (write only)
//
// One point per cycle while in_stall is low; after the row-store read done at
// the edge that takes a point, difference, multiply, add-and-round and
// queue-write stages follow before its first word is on the output.
// Points of the last row give two words, so there the single output port,
// which pops one queued word at a time, holds input back through in_stall.
// rst clears counters, queue and pipeline valids; the row stores hold no reset.
// in_stall rises when the result queue has room for fewer than two words;
// it does not follow out_stall within the same cycle.
`include "poisson_residual_stencil_top_macros.svh"

module poisson_residual_stencil_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [prs_pkg::VALUE_W-1:0]   u_value,
  input  logic signed [prs_pkg::VALUE_W-1:0]   f_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [prs_pkg::VALUE_W-1:0]   residual_value,
  output logic [prs_pkg::CNT_W-1:0]            out_col,
  output logic [prs_pkg::CNT_W-1:0]            out_row,
  output logic                                 grid_done,
  input  logic                                 cfg_write,
  input  logic [prs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prs_pkg::COEF_W-1:0]           cfg_data
);
  import prs_pkg::*;

  logic [CNT_W-1:0]  row_length_panels;
  logic [CNT_W-1:0]  row_count_panels;
  logic [COEF_W-1:0] coef_along_row;
  logic [COEF_W-1:0] coef_across_rows;

  logic [CNT_W-1:0]  col_counter, col_counter_next;
  logic [CNT_W-1:0]  row_counter, row_counter_next;
  logic [CNT_W-1:0]  nx, ny;
  logic              last_row, last_col;
  logic [CNT_W-1:0]  col_ahead;
  prs_meta_t         meta;
  logic              accept;

  logic [FIFO_CW-1:0] used, used_next;
  logic [FIFO_CW-1:0] n_need;
  logic               pop;

  logic                      st_valid;
  prs_meta_t                 st_meta;
  logic signed [DIFF_W-1:0]  st_dx, st_dy;
  logic signed [VALUE_W-1:0] st_f;

  logic                      res_valid;
  prs_meta_t                 res_meta;
  logic signed [VALUE_W-1:0] res_value;

  prs_result_t ent_int, ent_edge, ent_first, head;
  logic        wr_first, wr_second;
  logic        head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length_panels <= PANELS_RESET;
      row_count_panels  <= PANELS_RESET;
      coef_along_row    <= COEF_RESET;
      coef_across_rows  <= COEF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length_panels <= cfg_data[CNT_W-1:0];
        REG_ROW_COUNT:  row_count_panels  <= cfg_data[CNT_W-1:0];
        REG_COEF_X:     coef_along_row    <= cfg_data;
        REG_COEF_Y:     coef_across_rows  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign nx       = clamp_panels(row_length_panels);
  assign ny       = clamp_panels(row_count_panels);
  assign last_row = (row_counter >= ny);
  assign last_col = (col_counter >= nx);
  assign col_ahead = last_col ? '0 : col_counter + CNT_W'(1);

  always_comb begin
    meta.has_int   = (row_counter != '0);
    meta.interior  = (row_counter >= CNT_W'(2)) && (row_counter <= ny) &&
                     (col_counter != '0) && !last_col;
    meta.has_edge  = last_row;
    meta.edge_done = last_row && last_col;
    meta.col       = col_counter;
    meta.row       = row_counter;
  end

  // reserve queue room for every word a point will produce
  assign n_need   = FIFO_CW'(meta.has_int) + FIFO_CW'(meta.has_edge);
  assign in_stall = (used > FIFO_CW'(FIFO_DEPTH - 2));
  assign accept   = in_valid && !in_stall;
  assign pop      = head_valid && !out_stall;
  assign used_next = used + (accept ? n_need : '0) - FIFO_CW'(pop);

  always_comb begin
    col_counter_next = col_counter + CNT_W'(1);
    row_counter_next = row_counter;
    if (last_col) begin
      col_counter_next = '0;
      row_counter_next = last_row ? '0 : row_counter + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
      used        <= '0;
    end else begin
      used <= used_next;
      if (accept) begin
        col_counter <= col_counter_next;
        row_counter <= row_counter_next;
      end
    end
  end

  prs_row_store u_store (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .col       (col_counter),
    .col_ahead (col_ahead),
    .meta      (meta),
    .u_in      (u_value),
    .f_in      (f_value),
    .st_valid  (st_valid),
    .st_meta   (st_meta),
    .st_dx     (st_dx),
    .st_dy     (st_dy),
    .st_f      (st_f)
  );

  prs_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .st_valid  (st_valid),
    .st_meta   (st_meta),
    .st_dx     (st_dx),
    .st_dy     (st_dy),
    .st_f      (st_f),
    .coef_x    (coef_along_row),
    .coef_y    (coef_across_rows),
    .res_valid (res_valid),
    .res_meta  (res_meta),
    .res_value (res_value)
  );

  always_comb begin
    ent_int.value  = res_value;
    ent_int.col    = res_meta.col;
    ent_int.row    = res_meta.row - CNT_W'(1);
    ent_int.done   = 1'b0;
    ent_edge.value = '0;
    ent_edge.col   = res_meta.col;
    ent_edge.row   = res_meta.row;
    ent_edge.done  = res_meta.edge_done;
  end

  // the previous row's word goes first, the last-row boundary word second
  assign ent_first = res_meta.has_int ? ent_int : ent_edge;
  assign wr_first  = res_valid && (res_meta.has_int || res_meta.has_edge);
  assign wr_second = res_valid && res_meta.has_int && res_meta.has_edge;

  prs_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .wr_first   (wr_first),
    .wr_second  (wr_second),
    .ent_first  (ent_first),
    .ent_second (ent_edge),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_valid      = head_valid;
  assign residual_value = head.value;
  assign out_col        = head.col;
  assign out_row        = head.row;
  assign grid_done      = head.done;

  `PRS_ASSERT_NOW(a_credit_bound, 1'b1, used <= FIFO_CW'(FIFO_DEPTH), "queue reservations exceed depth")
  `PRS_ASSERT_NEXT(a_grid_wrap, accept && last_row && last_col, (col_counter == '0) && (row_counter == '0), "grid end did not wrap counters")
  `PRS_ASSERT_NEXT(a_col_step, accept && !last_col, col_counter == $past(col_counter) + CNT_W'(1), "column counter skipped")

endmodule
